// ===== src/ucep_pkg.sv =====
// Package for the USB endpoint-0 control handler.
// Holds the item structs, handler mode enum, event/action codes and request constants.
// No dependencies.
package ucep_pkg;

	// Endpoint-0 event codes
	localparam logic [1:0] OP_SETUP     = 2'd0;
	localparam logic [1:0] OP_RX_OTHER  = 2'd1;
	localparam logic [1:0] OP_TX_DONE   = 2'd2;
	localparam logic [1:0] OP_BUS_RESET = 2'd3;

	// Endpoint-0 actions
	localparam logic [2:0] ACT_NONE     = 3'd0;
	localparam logic [2:0] ACT_ZLP      = 3'd1;
	localparam logic [2:0] ACT_STALL    = 3'd2;
	localparam logic [2:0] ACT_DEV_DESC = 3'd3;
	localparam logic [2:0] ACT_CFG_DESC = 3'd4;

	// Standard request fields
	localparam logic [7:0] RT_DEVICE_OUT    = 8'h00;
	localparam logic [7:0] RT_DEVICE_IN     = 8'h80;
	localparam logic [7:0] RT_INTERFACE_OUT = 8'h01;
	localparam logic [7:0] RT_ENDPOINT_OUT  = 8'h02;

	localparam logic [7:0] REQ_CLEAR_FEATURE  = 8'h01;
	localparam logic [7:0] REQ_SET_ADDRESS    = 8'h05;
	localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'h06;
	localparam logic [7:0] REQ_SET_CONFIG     = 8'h09;
	localparam logic [7:0] REQ_SET_INTERFACE  = 8'h0b;

	localparam logic [7:0] DESC_DEVICE = 8'h01;
	localparam logic [7:0] DESC_CONFIG = 8'h02;

	// Descriptor lengths and minimum setup size in bytes
	localparam logic [5:0] DEV_DESC_LEN  = 6'd18;
	localparam logic [5:0] CFG_DESC_LEN  = 6'd32;
	localparam logic [9:0] SETUP_MIN_LEN = 10'd8;

	typedef enum logic [1:0] {
		MODE_IDLE           = 2'd0,
		MODE_SET_ADDRESS    = 2'd1,
		MODE_AWAIT_TX       = 2'd2,
		MODE_GET_DESCRIPTOR = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [9:0]  received_count;
		logic [7:0]  request_type;
		logic [7:0]  request_code;
		logic [15:0] request_value;
		logic [15:0] request_length;
	} in_item_t;

	typedef struct packed {
		logic [2:0] ep0_action;
		logic [5:0] send_length;
		logic       rearm_receive;
		logic       start_data_endpoints;
		logic [6:0] device_address;
		logic [1:0] handler_mode;
	} out_item_t;

endpackage

// ===== src/usb_control_endpoint_handler.sv =====
// USB endpoint-0 control handler: decodes endpoint-0 events and standard requests.
// Depends on ucep_pkg.
//
// Path: input register, then the combinational decode, then the result register.
// Throughput: one item per cycle unless results stall; the decode is a single pass.
// Reset: mode idle, pending and applied addresses 0, both stages empty.
module usb_control_endpoint_handler (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  ucep_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output ucep_pkg::out_item_t result
);

	logic                valid_s1;
	ucep_pkg::in_item_t  item_s1;
	logic                advance;
	logic                process;

	ucep_pkg::mode_t     mode_q, mode_d;
	logic [6:0]          pend_addr_q, pend_addr_d;
	logic [6:0]          appl_addr_q, appl_addr_d;

	logic [2:0]          act;
	logic [5:0]          len;
	logic                rearm;
	logic                start;
	logic                setup_ok;
	ucep_pkg::out_item_t result_q;
	logic                result_valid_q;

	// Handshake: result stage frees when empty or taken
	assign advance    = !result_valid_q || result_ready;
	assign process    = valid_s1 && advance;
	assign item_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	assign setup_ok = item_s1.received_count >= ucep_pkg::SETUP_MIN_LEN;

	// Next state: mode and addresses
	always_comb begin
		mode_d      = mode_q;
		pend_addr_d = pend_addr_q;
		appl_addr_d = appl_addr_q;
		unique case (item_s1.operation)
			ucep_pkg::OP_SETUP: begin
				if (setup_ok) begin
					priority if (item_s1.request_type == ucep_pkg::RT_DEVICE_OUT &&
							item_s1.request_code == ucep_pkg::REQ_SET_ADDRESS) begin
						mode_d      = ucep_pkg::MODE_SET_ADDRESS;
						pend_addr_d = item_s1.request_value[6:0];
					end else if (item_s1.request_type == ucep_pkg::RT_DEVICE_OUT &&
							item_s1.request_code == ucep_pkg::REQ_SET_CONFIG) begin
						mode_d = ucep_pkg::MODE_AWAIT_TX;
					end else if (item_s1.request_type == ucep_pkg::RT_DEVICE_IN &&
							item_s1.request_code == ucep_pkg::REQ_GET_DESCRIPTOR &&
							(item_s1.request_value[15:8] == ucep_pkg::DESC_DEVICE ||
							item_s1.request_value[15:8] == ucep_pkg::DESC_CONFIG)) begin
						mode_d = ucep_pkg::MODE_GET_DESCRIPTOR;
					end else if ((item_s1.request_type == ucep_pkg::RT_INTERFACE_OUT &&
							item_s1.request_code == ucep_pkg::REQ_SET_INTERFACE) ||
							(item_s1.request_type == ucep_pkg::RT_ENDPOINT_OUT &&
							item_s1.request_code == ucep_pkg::REQ_CLEAR_FEATURE)) begin
						mode_d = ucep_pkg::MODE_AWAIT_TX;
					end else begin
						mode_d = mode_q;
					end
				end
			end
			ucep_pkg::OP_RX_OTHER: begin
				if (mode_q == ucep_pkg::MODE_GET_DESCRIPTOR) begin
					mode_d = ucep_pkg::MODE_IDLE;
				end
			end
			ucep_pkg::OP_TX_DONE: begin
				unique case (mode_q)
					ucep_pkg::MODE_SET_ADDRESS: begin
						appl_addr_d = pend_addr_q;
						mode_d      = ucep_pkg::MODE_IDLE;
					end
					ucep_pkg::MODE_AWAIT_TX:       mode_d = ucep_pkg::MODE_IDLE;
					ucep_pkg::MODE_GET_DESCRIPTOR: mode_d = mode_q;
					default:                       mode_d = mode_q;
				endcase
			end
			default: begin
				// bus reset drops the address only
				appl_addr_d = '0;
			end
		endcase
	end

	// Outputs: action, length, rearm, bulk start
	always_comb begin
		act   = ucep_pkg::ACT_NONE;
		len   = '0;
		rearm = 1'b0;
		start = 1'b0;
		unique case (item_s1.operation)
			ucep_pkg::OP_SETUP: begin
				rearm = 1'b1;
				act   = ucep_pkg::ACT_STALL;
				if (setup_ok) begin
					priority if (item_s1.request_type == ucep_pkg::RT_DEVICE_OUT &&
							item_s1.request_code == ucep_pkg::REQ_SET_ADDRESS) begin
						act = ucep_pkg::ACT_ZLP;
					end else if (item_s1.request_type == ucep_pkg::RT_DEVICE_OUT &&
							item_s1.request_code == ucep_pkg::REQ_SET_CONFIG) begin
						act   = ucep_pkg::ACT_ZLP;
						start = 1'b1;
					end else if (item_s1.request_type == ucep_pkg::RT_DEVICE_IN &&
							item_s1.request_code == ucep_pkg::REQ_GET_DESCRIPTOR &&
							item_s1.request_value[15:8] == ucep_pkg::DESC_DEVICE) begin
						act = ucep_pkg::ACT_DEV_DESC;
						len = (item_s1.request_length < 16'(ucep_pkg::DEV_DESC_LEN)) ?
							item_s1.request_length[5:0] : ucep_pkg::DEV_DESC_LEN;
					end else if (item_s1.request_type == ucep_pkg::RT_DEVICE_IN &&
							item_s1.request_code == ucep_pkg::REQ_GET_DESCRIPTOR &&
							item_s1.request_value[15:8] == ucep_pkg::DESC_CONFIG) begin
						act = ucep_pkg::ACT_CFG_DESC;
						len = (item_s1.request_length < 16'(ucep_pkg::CFG_DESC_LEN)) ?
							item_s1.request_length[5:0] : ucep_pkg::CFG_DESC_LEN;
					end else if ((item_s1.request_type == ucep_pkg::RT_INTERFACE_OUT &&
							item_s1.request_code == ucep_pkg::REQ_SET_INTERFACE) ||
							(item_s1.request_type == ucep_pkg::RT_ENDPOINT_OUT &&
							item_s1.request_code == ucep_pkg::REQ_CLEAR_FEATURE)) begin
						act = ucep_pkg::ACT_ZLP;
					end else begin
						act = ucep_pkg::ACT_STALL;
					end
				end
			end
			ucep_pkg::OP_RX_OTHER: begin
				rearm = 1'b1;
			end
			ucep_pkg::OP_TX_DONE: begin
				// only a descriptor transfer closes with a zero-length status packet
				act = (mode_q == ucep_pkg::MODE_GET_DESCRIPTOR) ?
					ucep_pkg::ACT_ZLP : ucep_pkg::ACT_STALL;
			end
			default: begin
				rearm = 1'b1;
			end
		endcase
	end

	// Handler state, updated as each item moves into the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= ucep_pkg::MODE_IDLE;
			pend_addr_q <= '0;
			appl_addr_q <= '0;
		end else if (process) begin
			mode_q      <= mode_d;
			pend_addr_q <= pend_addr_d;
			appl_addr_q <= appl_addr_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			result_q.ep0_action           <= act;
			result_q.send_length          <= len;
			result_q.rearm_receive        <= rearm;
			result_q.start_data_endpoints <= start;
			result_q.device_address       <= appl_addr_d;
			result_q.handler_mode         <= mode_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== bench/ucep_event_checker.sv =====
`timescale 1ns / 100ps
// Checker for the USB endpoint-0 control handler: watches both item channels,
// predicts each result from the events accepted and compares field by field.
// Depends on ucep_pkg.
module ucep_event_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                item_ready,
	input  ucep_pkg::in_item_t  item,
	input  logic                result_valid,
	input  logic                result_ready,
	input  ucep_pkg::out_item_t result,
	output int                  fail_count,
	output int                  outstanding
);
	import ucep_pkg::*;

	// predicted handler state
	mode_t      ctl_mode;
	logic [6:0] held_addr;
	logic [6:0] live_addr;

	out_item_t expected_results[$];
	int        fails = 0;

	function automatic logic [5:0] clip_length(input logic [5:0] full, input logic [15:0] asked);
		return (asked < {10'd0, full}) ? asked[5:0] : full;
	endfunction

	// decode one endpoint-0 event and advance the predicted state
	function automatic out_item_t decode_event(input in_item_t ev);
		out_item_t r;
		logic [7:0] dtype;
		r = '0;
		r.ep0_action = ACT_NONE;
		dtype = ev.request_value[15:8];
		case (ev.operation)
			OP_SETUP: begin
				r.rearm_receive = 1'b1;
				r.ep0_action = ACT_STALL;
				// short setups and unknown requests stall without touching the mode
				if (ev.received_count >= SETUP_MIN_LEN) begin
					case (ev.request_type)
						RT_DEVICE_OUT: begin
							if (ev.request_code == REQ_SET_ADDRESS) begin
								ctl_mode = MODE_SET_ADDRESS;
								held_addr = ev.request_value[6:0];
								r.ep0_action = ACT_ZLP;
							end else if (ev.request_code == REQ_SET_CONFIG) begin
								ctl_mode = MODE_AWAIT_TX;
								r.start_data_endpoints = 1'b1;
								r.ep0_action = ACT_ZLP;
							end
						end
						RT_DEVICE_IN: begin
							if (ev.request_code == REQ_GET_DESCRIPTOR) begin
								if (dtype == DESC_DEVICE) begin
									ctl_mode = MODE_GET_DESCRIPTOR;
									r.ep0_action = ACT_DEV_DESC;
									r.send_length = clip_length(DEV_DESC_LEN, ev.request_length);
								end else if (dtype == DESC_CONFIG) begin
									ctl_mode = MODE_GET_DESCRIPTOR;
									r.ep0_action = ACT_CFG_DESC;
									r.send_length = clip_length(CFG_DESC_LEN, ev.request_length);
								end
							end
						end
						RT_INTERFACE_OUT: begin
							if (ev.request_code == REQ_SET_INTERFACE) begin
								ctl_mode = MODE_AWAIT_TX;
								r.ep0_action = ACT_ZLP;
							end
						end
						RT_ENDPOINT_OUT: begin
							if (ev.request_code == REQ_CLEAR_FEATURE) begin
								ctl_mode = MODE_AWAIT_TX;
								r.ep0_action = ACT_ZLP;
							end
						end
						default: ;
					endcase
				end
			end
			OP_RX_OTHER: begin
				if (ctl_mode == MODE_GET_DESCRIPTOR)
					ctl_mode = MODE_IDLE;
				r.rearm_receive = 1'b1;
			end
			OP_TX_DONE: begin
				// status stage done: a pending address takes effect here
				case (ctl_mode)
					MODE_SET_ADDRESS: begin
						live_addr = held_addr;
						ctl_mode = MODE_IDLE;
						r.ep0_action = ACT_STALL;
					end
					MODE_AWAIT_TX: begin
						ctl_mode = MODE_IDLE;
						r.ep0_action = ACT_STALL;
					end
					MODE_GET_DESCRIPTOR: r.ep0_action = ACT_ZLP;
					default: r.ep0_action = ACT_STALL;
				endcase
			end
			default: begin
				// bus reset clears the address only
				live_addr = '0;
				r.rearm_receive = 1'b1;
			end
		endcase
		r.device_address = live_addr;
		r.handler_mode = ctl_mode;
		return r;
	endfunction

	function automatic int field_differs(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got === want)
			return 0;
		$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		return 1;
	endfunction

	// result first: it always belongs to an earlier item
	always @(posedge clk or negedge arst_n) begin : checking
		out_item_t want;
		if (!arst_n) begin
			ctl_mode = MODE_IDLE;
			held_addr = '0;
			live_addr = '0;
			expected_results.delete();
		end else begin
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result %h with nothing expected", $time, result);
					fails++;
				end else begin
					want = expected_results.pop_front();
					fails += field_differs("ep0_action", 8'(want.ep0_action),
						8'(result.ep0_action));
					fails += field_differs("send_length", 8'(want.send_length),
						8'(result.send_length));
					fails += field_differs("rearm_receive", 8'(want.rearm_receive),
						8'(result.rearm_receive));
					fails += field_differs("start_data_endpoints",
						8'(want.start_data_endpoints), 8'(result.start_data_endpoints));
					fails += field_differs("device_address", 8'(want.device_address),
						8'(result.device_address));
					fails += field_differs("handler_mode", 8'(want.handler_mode),
						8'(result.handler_mode));
				end
			end
			if (item_valid && item_ready)
				expected_results.push_back(decode_event(item));
		end
		fail_count <= fails;
		outstanding <= expected_results.size();
	end

endmodule

// ===== bench/usb_control_endpoint_handler_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the USB endpoint-0 control handler: drives directed and random
// endpoint-0 events with bursty input and a stalling result side.
// Depends on ucep_pkg, usb_control_endpoint_handler and ucep_event_checker.
module usb_control_endpoint_handler_tb;
	import ucep_pkg::*;

	localparam int EVENT_TARGET = 1550;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 8;

	typedef enum {SINK_OPEN, SINK_RANDOM, SINK_SPARSE, SINK_PERIODIC} sink_style_t;

	logic      clk;
	logic      arst_n;
	logic      item_valid;
	logic      item_ready;
	in_item_t  item;
	logic      result_valid;
	logic      result_ready;
	out_item_t result;
	int        fail_count;
	int        outstanding;

	int events_sent = 0;
	int burst_left = 0;
	int hold_requests = 0;
	bit steady = 0;

	usb_control_endpoint_handler uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	ucep_event_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("status: fail");
		$finish;
	end

	// result side: changing stall styles, plus long hold-offs on request
	initial begin : result_sink
		sink_style_t style;
		int style_left;
		int tick;
		int holds_served;
		style = SINK_OPEN;
		style_left = 0;
		tick = 0;
		holds_served = 0;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			tick++;
			if (holds_served != hold_requests) begin
				holds_served++;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (style_left == 0) begin
				style = sink_style_t'($urandom_range(0, 3));
				style_left = $urandom_range(20, 200);
			end
			style_left--;
			case (style)
				SINK_OPEN:   result_ready <= 1'b1;
				SINK_RANDOM: result_ready <= 1'($urandom_range(0, 1));
				SINK_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
				default:     result_ready <= (tick % 4 != 3);
			endcase
		end
	end

	function automatic in_item_t req(input logic [1:0] op, input logic [9:0] count,
			input logic [7:0] rtype, input logic [7:0] code,
			input logic [15:0] value, input logic [15:0] length);
		in_item_t ev;
		ev.operation = op;
		ev.received_count = count;
		ev.request_type = rtype;
		ev.request_code = code;
		ev.request_value = value;
		ev.request_length = length;
		return ev;
	endfunction

	function automatic in_item_t random_event(input logic [1:0] op);
		return req(op, 10'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
			16'($urandom));
	endfunction

	// mostly lengths near the descriptor sizes, sometimes anything
	function automatic logic [15:0] asked_length();
		if ($urandom_range(0, 3) == 0)
			return 16'($urandom);
		return 16'($urandom_range(0, 40));
	endfunction

	function automatic in_item_t setup_request(input logic [7:0] rtype, input logic [7:0] code,
			input logic [15:0] value, input logic [15:0] length);
		logic [9:0] count;
		count = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(8, 1023)) : SETUP_MIN_LEN;
		return req(OP_SETUP, count, rtype, code, value, length);
	endfunction

	task automatic send_event(input in_item_t ev);
		@(negedge clk);
		item <= ev;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
	endtask

	// one item, then maybe a gap when the current burst runs out
	task automatic offer(input in_item_t ev);
		send_event(ev);
		events_sent++;
		if (steady)
			return;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat ($urandom_range(0, 9)) @(negedge clk);
			burst_left = $urandom_range(0, 40);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		item_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// one well-formed transfer, a broken one, or noise
	task automatic run_transfer();
		int pick;
		logic [7:0] dtype;
		logic [7:0] lo;
		in_item_t ev;
		pick = $urandom_range(0, 99);
		lo = 8'($urandom);
		if (pick < 20) begin
			offer(setup_request(RT_DEVICE_OUT, REQ_SET_ADDRESS, 16'($urandom),
				asked_length()));
			if ($urandom_range(0, 2) == 0)
				offer(random_event(OP_RX_OTHER));
			offer(random_event(OP_TX_DONE));
		end else if (pick < 45) begin
			dtype = $urandom_range(0, 1) ? DESC_DEVICE : DESC_CONFIG;
			offer(setup_request(RT_DEVICE_IN, REQ_GET_DESCRIPTOR, {dtype, lo}, asked_length()));
			repeat ($urandom_range(0, 2)) offer(random_event(OP_TX_DONE));
			if ($urandom_range(0, 3) != 0)
				offer(random_event(OP_RX_OTHER));
		end else if (pick < 60) begin
			case ($urandom_range(0, 2))
				0: offer(setup_request(RT_DEVICE_OUT, REQ_SET_CONFIG, 16'($urandom),
					asked_length()));
				1: offer(setup_request(RT_INTERFACE_OUT, REQ_SET_INTERFACE, 16'($urandom),
					asked_length()));
				default: offer(setup_request(RT_ENDPOINT_OUT, REQ_CLEAR_FEATURE,
					16'($urandom), asked_length()));
			endcase
			offer(random_event(OP_TX_DONE));
		end else if (pick < 68) begin
			offer(random_event(OP_BUS_RESET));
		end else if (pick < 80) begin
			case ($urandom_range(0, 3))
				0: begin
					ev = setup_request(RT_DEVICE_OUT, REQ_SET_ADDRESS, 16'($urandom),
						asked_length());
					ev.received_count = 10'($urandom_range(0, 7));
					offer(ev);
				end
				1: offer(setup_request(8'($urandom), 8'($urandom), 16'($urandom),
					16'($urandom)));
				2: offer(setup_request(RT_DEVICE_IN, REQ_GET_DESCRIPTOR, 16'($urandom),
					asked_length()));
				default: begin
					// bus reset between the setup and its status stage
					offer(setup_request(RT_DEVICE_OUT, REQ_SET_ADDRESS, 16'($urandom), 0));
					offer(random_event(OP_BUS_RESET));
					offer(random_event(OP_TX_DONE));
				end
			endcase
		end else begin
			offer(random_event(2'($urandom_range(0, 3))));
		end
	endtask

	initial begin : stimulus
		bit held;
		bit paused;
		held = 0;
		paused = 0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: idle events, short setups, address handling, descriptors, requests
		offer(req(OP_TX_DONE, 0, 0, 0, 0, 0));
		offer(req(OP_RX_OTHER, 10'h3ff, 8'hff, 8'hff, 16'hffff, 16'hffff));
		offer(req(OP_SETUP, 0, RT_DEVICE_OUT, REQ_SET_ADDRESS, 16'h0005, 0));
		offer(req(OP_SETUP, 7, RT_DEVICE_IN, REQ_GET_DESCRIPTOR, {DESC_DEVICE, 8'h00}, 18));
		offer(req(OP_SETUP, 10'h3ff, RT_DEVICE_OUT, REQ_SET_ADDRESS, 16'hffff, 16'hffff));
		offer(req(OP_TX_DONE, 0, 0, 0, 0, 0));
		offer(req(OP_BUS_RESET, 10'h3ff, 8'hff, 8'hff, 16'hffff, 16'hffff));
		offer(req(OP_SETUP, 8, RT_DEVICE_OUT, REQ_SET_ADDRESS, 16'h0005, 0));
		offer(req(OP_RX_OTHER, 0, 0, 0, 0, 0));
		offer(req(OP_TX_DONE, 10'h3ff, 8'hff, 8'hff, 16'hffff, 16'hffff));
		offer(req(OP_SETUP, 8, RT_DEVICE_IN, REQ_GET_DESCRIPTOR, {DESC_DEVICE, 8'h00}, 0));
		offer(req(OP_SETUP, 8, RT_DEVICE_IN, REQ_GET_DESCRIPTOR, {DESC_DEVICE, 8'hff},
			16'hffff));
		offer(req(OP_RX_OTHER, 0, 0, 0, 0, 0));
		offer(req(OP_SETUP, 8, RT_DEVICE_IN, REQ_GET_DESCRIPTOR, {DESC_CONFIG, 8'h00}, 17));
		offer(req(OP_SETUP, 9, RT_DEVICE_IN, REQ_GET_DESCRIPTOR, {DESC_CONFIG, 8'h00}, 32));
		offer(req(OP_SETUP, 8, RT_DEVICE_IN, REQ_GET_DESCRIPTOR, {DESC_CONFIG, 8'h00}, 33));
		offer(req(OP_TX_DONE, 0, 0, 0, 0, 0));
		offer(req(OP_TX_DONE, 0, 0, 0, 0, 0));
		offer(req(OP_BUS_RESET, 0, 0, 0, 0, 0));
		offer(req(OP_RX_OTHER, 0, 0, 0, 0, 0));
		offer(req(OP_SETUP, 8, RT_DEVICE_IN, REQ_GET_DESCRIPTOR, 16'h0300, 64));
		offer(req(OP_SETUP, 8, RT_DEVICE_IN, REQ_GET_DESCRIPTOR, 16'hff00, 64));
		offer(req(OP_SETUP, 8, RT_DEVICE_OUT, REQ_SET_CONFIG, 16'h0001, 0));
		offer(req(OP_TX_DONE, 0, 0, 0, 0, 0));
		offer(req(OP_SETUP, 8, RT_INTERFACE_OUT, REQ_SET_INTERFACE, 0, 0));
		offer(req(OP_SETUP, 8, RT_ENDPOINT_OUT, REQ_CLEAR_FEATURE, 0, 0));
		offer(req(OP_TX_DONE, 0, 0, 0, 0, 0));
		offer(req(OP_SETUP, 8, 8'hff, 8'hff, 16'hffff, 16'hffff));
		offer(req(OP_SETUP, 8, RT_DEVICE_OUT, REQ_GET_DESCRIPTOR, {DESC_DEVICE, 8'h00}, 18));

		// random transfers, with one long result hold-off and one full drain
		while (events_sent < EVENT_TARGET) begin
			if (!held && events_sent >= 400) begin
				held = 1;
				@(posedge clk);
				hold_requests++;
				steady = 1;
				repeat (24) run_transfer();
				steady = 0;
			end
			if (!paused && events_sent >= 900) begin
				paused = 1;
				wait_drained();
				repeat ($urandom_range(5, 20)) @(negedge clk);
			end
			run_transfer();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
